// File: rtl/sjf_pkg.sv
package sjf_pkg;

  localparam int MaxProcsDef = 16;
  localparam int BurstW      = 16;
  localparam int ArrW        = 16;
  localparam int JobIdW      = 5;
  localparam int WaitW       = 20;
  localparam int FinW        = 21;
  localparam int TatW        = 21;

  typedef struct packed {
    logic [BurstW-1:0] burst_time;
    logic [ArrW-1:0]   arrival_time;
    logic              last_job;
  } job_t;

  typedef struct packed {
    logic [JobIdW-1:0] job_id;
    logic [WaitW-1:0]  wait_time;
    logic [FinW-1:0]   finish_time;
    logic [TatW-1:0]   turnaround;
    logic              final_result;
  } result_t;

  typedef struct packed {
    logic              best_vld;
    logic [BurstW-1:0] best_burst;
    logic [ArrW-1:0]   best_arr;
    logic              early_vld;
    logic [ArrW-1:0]   early_arr;
  } pick_t;

endpackage

// File: rtl/sjf_job_mem.sv
module sjf_job_mem #(
  parameter int Depth = sjf_pkg::MaxProcsDef,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  parameter int DataW = sjf_pkg::BurstW + sjf_pkg::ArrW
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// File: rtl/sjf_pick_unit.sv
module sjf_pick_unit #(
  parameter int IdxW = 4,
  parameter int ClkW = 21
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  logic                      vld_i,
  input  logic [IdxW-1:0]           idx_i,
  input  logic [sjf_pkg::BurstW-1:0] burst_i,
  input  logic [sjf_pkg::ArrW-1:0]  arr_i,
  input  logic                      done_i,
  input  logic [ClkW-1:0]           clock_i,
  output logic [IdxW-1:0]           best_idx_o,
  output sjf_pkg::pick_t            pick_o
);

  import sjf_pkg::*;

  pick_t           pick_d, pick_q;
  logic [IdxW-1:0] idx_d, idx_q;
  logic            arrived;
  logic            better;

  always_comb begin
    pick_d  = pick_q;
    idx_d   = idx_q;
    arrived = ClkW'(arr_i) <= clock_i;
    better  = !pick_q.best_vld || (burst_i < pick_q.best_burst) ||
              ((burst_i == pick_q.best_burst) && (arr_i < pick_q.best_arr));
    if (clr_i) begin
      pick_d.best_vld  = 1'b0;
      pick_d.early_vld = 1'b0;
    end else if (vld_i && !done_i) begin
      if (!pick_q.early_vld || (arr_i < pick_q.early_arr)) begin
        pick_d.early_vld = 1'b1;
        pick_d.early_arr = arr_i;
      end
      if (arrived && better) begin
        pick_d.best_vld   = 1'b1;
        pick_d.best_burst = burst_i;
        pick_d.best_arr   = arr_i;
        idx_d             = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_q <= '0;
      idx_q  <= '0;
    end else begin
      pick_q <= pick_d;
      idx_q  <= idx_d;
    end
  end

  assign pick_o     = pick_q;
  assign best_idx_o = idx_q;

endmodule

// File: rtl/sjf_nonpreemptive_scheduler_unit.sv
// Shortest-job-first scheduler. Each start taken while idle loads one job into
// the job memory while it has room; the job marked last starts the schedule,
// and busy stays high until the cycle that shows the final result of the batch,
// in which it falls. Each scheduled job costs one scan of the job memory through
// the single compare unit, and a gap with no arrived job costs one more scan.
// Results appear for one cycle on result_valid_o and must be taken then, because
// the receiver cannot stall the block.
module sjf_nonpreemptive_scheduler_unit #(
  parameter int MaxProcs = sjf_pkg::MaxProcsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  sjf_pkg::job_t    job_i,
  output logic             busy,
  output logic             result_valid_o,
  output sjf_pkg::result_t result_o
);

  import sjf_pkg::*;

  localparam int IdxW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int CntW = $clog2(MaxProcs + 1);
  localparam int ClkW = ArrW + $clog2(MaxProcs + 1);
  localparam int MemW = BurstW + ArrW;

  typedef enum logic [1:0] {StIdle, StScan, StEval, StOut} state_e;

  state_e              state_d, state_q;
  logic [CntW-1:0]     count_d, count_q;
  logic [CntW-1:0]     n_d, n_q;
  logic [CntW-1:0]     scan_d, scan_q;
  logic [CntW-1:0]     emit_d, emit_q;
  logic [ClkW-1:0]     clock_d, clock_q;
  logic [ClkW-1:0]     wait_d, wait_q;
  logic [ClkW-1:0]     fin_d, fin_q;
  logic [MaxProcs-1:0] done_d, done_q;
  logic                dvld_d, dvld_q;
  logic [IdxW-1:0]     didx_d, didx_q;
  logic                rvld_d, rvld_q;
  result_t             res_d, res_q;

  logic                accept;
  logic                wr_en;
  logic                issue;
  logic                clr;
  logic [MemW-1:0]     rd_data;
  logic [IdxW-1:0]     best_idx;
  pick_t               pick;
  logic [IdxW:0]       id_full;
  logic [ClkW-1:0]     tat;

  assign accept = start && (state_q == StIdle);
  assign wr_en  = accept && (count_q < CntW'(MaxProcs));
  assign issue  = (state_q == StScan) && (scan_q < n_q);

  sjf_job_mem #(
    .Depth (MaxProcs),
    .AddrW (IdxW),
    .DataW (MemW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i ({job_i.burst_time, job_i.arrival_time}),
    .rd_addr_i (scan_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  sjf_pick_unit #(
    .IdxW (IdxW),
    .ClkW (ClkW)
  ) u_pick (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (clr),
    .vld_i      (dvld_q),
    .idx_i      (didx_q),
    .burst_i    (rd_data[MemW-1:ArrW]),
    .arr_i      (rd_data[ArrW-1:0]),
    .done_i     (done_q[didx_q]),
    .clock_i    (clock_q),
    .best_idx_o (best_idx),
    .pick_o     (pick)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    scan_d  = scan_q;
    emit_d  = emit_q;
    clock_d = clock_q;
    wait_d  = wait_q;
    fin_d   = fin_q;
    done_d  = done_q;
    rvld_d  = 1'b0;
    res_d   = res_q;
    clr     = 1'b0;
    dvld_d  = issue;
    didx_d  = scan_q[IdxW-1:0];
    id_full = {1'b0, best_idx} + (IdxW + 1)'(1);
    tat     = fin_q - ClkW'(pick.best_arr);
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (wr_en) begin
            count_d = count_q + CntW'(1);
          end
          if (job_i.last_job) begin
            n_d     = wr_en ? count_q + CntW'(1) : count_q;
            scan_d  = '0;
            emit_d  = '0;
            clock_d = '0;
            clr     = 1'b1;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (issue) begin
          scan_d = scan_q + CntW'(1);
        end
        if (dvld_q && (CntW'(didx_q) == n_q - CntW'(1))) begin
          state_d = StEval;
        end
      end
      StEval: begin
        scan_d = '0;
        if (pick.best_vld) begin
          wait_d           = clock_q - ClkW'(pick.best_arr);
          fin_d            = clock_q + ClkW'(pick.best_burst);
          done_d[best_idx] = 1'b1;
          state_d          = StOut;
        end else begin
          clock_d = ClkW'(pick.early_arr);
          clr     = 1'b1;
          state_d = StScan;
        end
      end
      StOut: begin
        rvld_d             = 1'b1;
        res_d.job_id       = JobIdW'(id_full);
        res_d.wait_time    = WaitW'(wait_q);
        res_d.finish_time  = FinW'(fin_q);
        res_d.turnaround   = TatW'(tat);
        res_d.final_result = (emit_q + CntW'(1)) == n_q;
        emit_d             = emit_q + CntW'(1);
        clock_d            = fin_q;
        if ((emit_q + CntW'(1)) == n_q) begin
          count_d = '0;
          done_d  = '0;
          clock_d = '0;
          state_d = StIdle;
        end else begin
          clr     = 1'b1;
          state_d = StScan;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      n_q     <= '0;
      scan_q  <= '0;
      emit_q  <= '0;
      clock_q <= '0;
      wait_q  <= '0;
      fin_q   <= '0;
      done_q  <= '0;
      dvld_q  <= 1'b0;
      didx_q  <= '0;
      rvld_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      scan_q  <= scan_d;
      emit_q  <= emit_d;
      clock_q <= clock_d;
      wait_q  <= wait_d;
      fin_q   <= fin_d;
      done_q  <= done_d;
      dvld_q  <= dvld_d;
      didx_q  <= didx_d;
      rvld_q  <= rvld_d;
      res_q   <= res_d;
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = rvld_q;
  assign result_o       = res_q;

endmodule

// File: rtl/sjf_checker.sv
module sjf_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input sjf_pkg::job_t    job_i,
  input logic             busy,
  input logic             result_valid_o,
  input sjf_pkg::result_t result_o
);

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !job_i.last_job |=> !busy)
    else $error("Loading a job that is not last must leave the block idle.");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && job_i.last_job |=> busy)
    else $error("The last job must start the schedule.");

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.final_result |-> busy)
    else $error("The block must stay busy while results of the batch remain.");

  a_final_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.final_result |-> !busy)
    else $error("The final result must leave the block idle.");

  a_result_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("Two results must never appear in consecutive cycles.");

endmodule

bind sjf_nonpreemptive_scheduler_unit sjf_checker u_sjf_checker (.*);

// File: test/tb_top.sv
module tb_top;
  import sjf_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int TotalJobs = 280;

  class sjf_scoreboard;
    logic [BurstW-1:0] burst_mem[MaxProcsDef];
    logic [ArrW-1:0]   arrival_mem[MaxProcsDef];
    int unsigned       held;
    result_t           expected_q[$];
    int                errors;
    int                checked;

    function new();
      held = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void note_job(job_t j);
      if (held < MaxProcsDef) begin
        burst_mem[held] = j.burst_time;
        arrival_mem[held] = j.arrival_time;
        held++;
      end
      if (j.last_job) begin
        schedule_batch();
      end
    endfunction

    function void schedule_batch();
      bit          done[MaxProcsDef];
      int unsigned now;
      int unsigned earliest;
      int unsigned fin;
      int unsigned emitted;
      int          pick;
      result_t     r;
      foreach (done[i]) done[i] = 1'b0;
      now = 0;
      emitted = 0;
      while (emitted < held) begin
        pick = -1;
        earliest = 32'hFFFF_FFFF;
        for (int i = 0; i < held; i++) begin
          if (done[i]) continue;
          if (arrival_mem[i] < earliest) earliest = 32'(arrival_mem[i]);
          if (arrival_mem[i] > now) continue;
          if (pick < 0 || burst_mem[i] < burst_mem[pick] ||
              (burst_mem[i] == burst_mem[pick] && arrival_mem[i] < arrival_mem[pick])) begin
            pick = i;
          end
        end
        if (pick < 0) begin
          now = earliest;
        end else begin
          fin = now + burst_mem[pick];
          r.job_id = JobIdW'(pick + 1);
          r.wait_time = WaitW'(now - arrival_mem[pick]);
          r.finish_time = FinW'(fin);
          r.turnaround = TatW'(fin - arrival_mem[pick]);
          r.final_result = (emitted + 1 == held);
          expected_q.push_back(r);
          now = fin;
          done[pick] = 1'b1;
          emitted++;
        end
      end
      held = 0;
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("Result transfer with nothing expected: job_id %0d", got.job_id);
        errors++;
      end else begin
        want = expected_q.pop_front();
        compare_field("job_id", 64'(want.job_id), 64'(got.job_id));
        compare_field("wait_time", 64'(want.wait_time), 64'(got.wait_time));
        compare_field("finish_time", 64'(want.finish_time), 64'(got.finish_time));
        compare_field("turnaround", 64'(want.turnaround), 64'(got.turnaround));
        compare_field("final_result", 64'(want.final_result), 64'(got.final_result));
        checked++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  job_t    job_i;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;

  sjf_scoreboard sb = new();
  int  idle_cycles;
  int  jobs_sent;
  int  batches;
  bit  no_gaps;

  sjf_nonpreemptive_scheduler_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .job_i          (job_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result(result_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_job(logic [BurstW-1:0] b, logic [ArrW-1:0] a, logic l);
    job_t j;
    int   gap;
    j.burst_time = b;
    j.arrival_time = a;
    j.last_job = l;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    job_i <= j;
    do @(posedge clk_i); while (busy);
    sb.note_job(j);
    jobs_sent++;
    if (l) batches++;
  endtask

  task automatic send_random_batch();
    int size;
    int mode;
    logic [BurstW-1:0] b;
    logic [ArrW-1:0]   a;
    no_gaps = ($urandom_range(0, 3) == 0);
    mode = $urandom_range(0, 3);
    size = ($urandom_range(0, 7) == 0) ? $urandom_range(MaxProcsDef + 1, MaxProcsDef + 3)
                                       : $urandom_range(1, MaxProcsDef);
    for (int i = 0; i < size; i++) begin
      case (mode)
        0: begin
          b = BurstW'($urandom_range(0, 15));
          a = ArrW'($urandom_range(0, 40));
        end
        1: begin
          b = BurstW'($urandom);
          a = ArrW'($urandom);
        end
        2: begin
          b = BurstW'($urandom_range(0, 7));
          a = ArrW'($urandom);
        end
        default: begin
          b = ($urandom_range(0, 2) == 0) ? 16'hFFFF : BurstW'($urandom_range(0, 3));
          a = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        end
      endcase
      send_job(b, a, i == size - 1);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    job_i = '0;
    idle_cycles = 0;
    jobs_sent = 0;
    batches = 0;
    no_gaps = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_job(16'd0, 16'd0, 1'b1);
    send_job(16'hFFFF, 16'hFFFF, 1'b1);
    send_job(16'd7, 16'd20, 1'b0);
    send_job(16'd3, 16'd20, 1'b0);
    send_job(16'd3, 16'd20, 1'b0);
    send_job(16'd3, 16'd15, 1'b0);
    send_job(16'd9, 16'd100, 1'b1);
    send_job(16'd0, 16'd0, 1'b0);
    send_job(16'd0, 16'd0, 1'b1);
    for (int i = 0; i < MaxProcsDef; i++) begin
      send_job(16'hFFFF, 16'hFFFF, 1'b0);
    end
    send_job(BurstW'($urandom), ArrW'($urandom), 1'b0);
    send_job(BurstW'($urandom), ArrW'($urandom), 1'b1);

    while (jobs_sent < TotalJobs) begin
      send_random_batch();
    end
    start <= 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d jobs in %0d batches, including ties, idle gaps and overflow.",
             jobs_sent, batches);
    $display("Checked %0d scheduled results field by field.", sb.checked);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
